// ----- rtl/encoder_wheel_speed_estimator_core_assert.svh -----
// Assertion macros for the wheel speed estimator checker.
// Used by the checker file only; needs i_clk and i_rst_n in the including scope.
`ifndef ENCODER_WHEEL_SPEED_ESTIMATOR_CORE_ASSERT_SVH
`define ENCODER_WHEEL_SPEED_ESTIMATOR_CORE_ASSERT_SVH

// Property checked outside reset.
`define EWSE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Property checked at every edge, reset included.
`define EWSE_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- rtl/ewse_pkg.sv -----
// Shared constants and types of the wheel speed estimator.
// Used by every module of the block; depends on nothing.
`default_nettype none

package ewse_pkg;

    // Widths of the data path.
    localparam int C_POS_W   = 32;   // position counter
    localparam int C_RPM_W   = 24;   // Q16.8 speed values
    localparam int C_TPR_W   = 16;   // ticks per revolution
    localparam int C_MS_W    = 16;   // elapsed milliseconds
    localparam int C_MA_W    = 33;   // multiplier operand A (signed)
    localparam int C_MB_W    = 25;   // multiplier operand B (signed)
    localparam int C_PROD_W  = C_MA_W + C_MB_W;
    localparam int C_NUM_W   = 56;   // dividend: magnitude times scale
    localparam int C_DEN_W   = 32;   // divisor: elapsed times ticks
    localparam int C_Q_W     = 24;   // quotient bits below the overflow step
    localparam int C_DIV_STEPS = C_Q_W + 1;
    localparam int C_DIV_CNT_W = $clog2(C_DIV_STEPS);
    localparam int C_ACC_W   = 44;   // filter accumulator
    localparam int C_FRAC_W  = 16;   // coefficient fraction bits
    localparam int C_PADDR_W = 3;
    localparam int C_PDATA_W = 32;

    // Coefficients and scale.
    localparam logic [C_TPR_W-1:0]  C_COEF_A    = 16'd55968;    // 0.854 in Q0.16
    localparam logic [C_TPR_W-1:0]  C_COEF_B    = 16'd4771;     // 0.0728 in Q0.16
    localparam logic [23:0]         C_RPM_SCALE = 24'd15360000; // 60000 * 256
    localparam logic [C_TPR_W-1:0]  C_TPR_RESET = 16'd1050;
    localparam logic signed [C_RPM_W-1:0] C_RPM_MAX = 24'sh7FFFFF;
    localparam logic signed [C_RPM_W-1:0] C_RPM_MIN = 24'sh800000;
    localparam logic signed [C_ACC_W-1:0] C_ROUND   = 44'sd32768;

    // Codes.
    localparam logic C_ACT_EDGE   = 1'b0;
    localparam logic C_ACT_SAMPLE = 1'b1;
    localparam logic C_PHASE_UP   = 1'b0;
    localparam logic C_REG_TPR    = 1'b0;

    typedef enum logic [11:0] {
        S_IDLE      = 12'b0000_0000_0001,
        S_MUL_NUM   = 12'b0000_0000_0010,
        S_MUL_DEN   = 12'b0000_0000_0100,
        S_DIV_START = 12'b0000_0000_1000,
        S_DIV_WAIT  = 12'b0000_0001_0000,
        S_F_A       = 12'b0000_0010_0000,
        S_F_B1      = 12'b0000_0100_0000,
        S_F_B2      = 12'b0000_1000_0000,
        S_F_SUM     = 12'b0001_0000_0000,
        S_F_OUT     = 12'b0010_0000_0000,
        S_OUT       = 12'b0100_0000_0000
    } t_state;

    typedef struct packed {
        logic signed [C_MA_W-1:0] a;
        logic signed [C_MB_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic               start;
        logic [C_NUM_W-1:0] num;
        logic [C_DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic             ovf;
        logic [C_Q_W-1:0] quot;
    } t_div_rsp;

endpackage

`default_nettype wire

// ----- rtl/ewse_mul.sv -----
// Shared signed multiplier with a registered product.
// Depends on ewse_pkg.
`default_nettype none

module ewse_mul (
    input  wire                                         i_clk,
    input  ewse_pkg::t_mul_req                          i_req,
    output logic signed [ewse_pkg::C_PROD_W-1:0]        o_prod
);
    import ewse_pkg::*;

    logic signed [C_PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_req.a * i_req.b;
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

// ----- rtl/ewse_div.sv -----
// Restoring divider, one quotient bit per cycle, with an overflow step first.
// Depends on ewse_pkg.
`default_nettype none

module ewse_div (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  ewse_pkg::t_div_req  i_req,
    output ewse_pkg::t_div_rsp  o_rsp
);
    import ewse_pkg::*;

    logic [C_NUM_W-1:0]     r_rem;
    logic [C_NUM_W-1:0]     r_dvs;
    logic [C_Q_W-1:0]       r_quot;
    logic                   r_ovf;
    logic [C_DIV_CNT_W-1:0] r_cnt;
    logic                   r_busy;
    logic                   r_done;
    logic [C_NUM_W:0]       w_sub;
    logic                   w_ge;

    // One subtract gives both the compare and the new remainder.
    assign w_sub = {1'b0, r_rem} - {1'b0, r_dvs};
    assign w_ge  = !w_sub[C_NUM_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == C_DIV_CNT_W'(C_DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= i_req.num;
            r_dvs  <= {i_req.den, {C_Q_W{1'b0}}};
            r_quot <= '0;
            r_ovf  <= 1'b0;
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= w_sub[C_NUM_W-1:0];
            end
            r_dvs <= r_dvs >> 1;
            // The first step tests against the divisor shifted past the quotient width.
            if (r_cnt == '0) begin
                r_ovf <= w_ge;
            end else begin
                r_quot <= {r_quot[C_Q_W-2:0], w_ge};
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.ovf  = r_ovf;
    assign o_rsp.quot = r_quot;

endmodule

`default_nettype wire

// ----- rtl/encoder_wheel_speed_estimator_core.sv -----
// Top level of the encoder wheel speed estimator: sequencer, state and ports.
// Depends on ewse_pkg, ewse_mul and ewse_div.
//
// Usage. Requests arrive on the input channel (i_in_valid / o_in_ready) with
// i_action, i_other_phase and i_elapsed_ms. An edge request (action 0) moves the
// position counter by one and yields no result, and the block is ready again in
// the next cycle. A sample request (action 1) yields exactly one result on the
// output channel (o_out_valid / i_out_ready) carrying the filtered speed, the
// position and the time error flag.
// Steps: a sample with non-zero elapsed time runs two multiplier passes and a
// start step, the 25-step divider, three filter products, a sum, a commit and
// the output load. A sample with zero elapsed time goes straight to the output
// load. The block takes no new request until a sample is through; edges are
// taken one per cycle while the block is idle.
// The result sits in an output register; if the receiver stalls, a completed
// sample waits in the final state until the register is free, and edges may be
// accepted while an earlier result is still waiting.
// Reset (synchronous, active low) clears the position, the filter state and the
// output valid flag, and loads 1050 into ticks_per_rev. The APB port writes
// ticks_per_rev at byte address 0 and must only be used while the block is idle.
`default_nettype none

module encoder_wheel_speed_estimator_core (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    // Input channel
    input  wire                                     i_in_valid,
    output logic                                    o_in_ready,
    input  wire                                     i_action,
    input  wire                                     i_other_phase,
    input  wire  [ewse_pkg::C_MS_W-1:0]             i_elapsed_ms,
    // Output channel
    output logic                                    o_out_valid,
    input  wire                                     i_out_ready,
    output logic signed [ewse_pkg::C_RPM_W-1:0]     o_filtered_rpm,
    output logic signed [ewse_pkg::C_POS_W-1:0]     o_position_count,
    output logic                                    o_time_error,
    // Configuration port
    input  wire                                     psel,
    input  wire                                     penable,
    input  wire                                     pwrite,
    input  wire  [ewse_pkg::C_PADDR_W-1:0]          paddr,
    input  wire  [ewse_pkg::C_PDATA_W-1:0]          pwdata,
    output logic [ewse_pkg::C_PDATA_W-1:0]          prdata,
    output logic                                    pready
);
    import ewse_pkg::*;

    t_state r_state, n_state;

    // Architectural state.
    logic [C_POS_W-1:0]         r_pos;
    logic [C_POS_W-1:0]         r_last;
    logic signed [C_RPM_W-1:0]  r_y;
    logic signed [C_RPM_W-1:0]  r_xp;
    logic [C_TPR_W-1:0]         r_tpr;

    // Working registers of one sample.
    logic [C_POS_W-1:0]         r_mag;
    logic                       r_neg;
    logic [C_MS_W-1:0]          r_elapsed;
    logic                       r_terr;
    logic [C_NUM_W-1:0]         r_num;
    logic signed [C_RPM_W-1:0]  r_x;
    logic signed [C_ACC_W-1:0]  r_acc;

    // Output register.
    logic                       r_out_valid;
    logic signed [C_RPM_W-1:0]  r_out_rpm;
    logic [C_POS_W-1:0]         r_out_pos;
    logic                       r_out_terr;

    logic                       w_in_acc;
    logic                       w_cfg_wr;
    logic                       w_out_load;
    logic [C_POS_W-1:0]         w_delta;
    logic [C_TPR_W-1:0]         w_tpr;
    logic signed [C_RPM_W-1:0]  w_x;
    logic signed [C_ACC_W-C_FRAC_W-1:0] w_y_wide;
    logic signed [C_RPM_W-1:0]  w_y_sat;
    logic signed [C_PROD_W-1:0] w_prod;
    t_mul_req                   w_mul_req;
    t_div_req                   w_div_req;
    t_div_rsp                   w_div_rsp;

    ewse_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (w_mul_req),
        .o_prod (w_prod)
    );

    ewse_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_out_load = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    // Configuration port: zero-wait APB, one register.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign prdata   = (paddr[C_PADDR_W-1] == C_REG_TPR) ?
                      {{(C_PDATA_W - C_TPR_W){1'b0}}, r_tpr} : '0;

    // Signed position change since the last good sample, split into sign and magnitude.
    assign w_delta = r_pos - r_last;
    // A tick count of zero behaves as one.
    assign w_tpr   = (r_tpr == '0) ? C_TPR_W'(1) : r_tpr;

    // Raw speed from the quotient: clamp the magnitude, then apply the sign.
    always_comb begin
        if (r_neg) begin
            if (w_div_rsp.ovf || (w_div_rsp.quot > 24'h800000)) begin
                w_x = C_RPM_MIN;
            end else begin
                w_x = $signed(C_RPM_W'(0) - w_div_rsp.quot);
            end
        end else begin
            if (w_div_rsp.ovf || w_div_rsp.quot[C_Q_W-1]) begin
                w_x = C_RPM_MAX;
            end else begin
                w_x = $signed(w_div_rsp.quot);
            end
        end
    end

    // The arithmetic shift of the rounded sum is a floor, which with the bias
    // added earlier rounds to nearest with ties upwards.
    assign w_y_wide = $signed(r_acc[C_ACC_W-1:C_FRAC_W]);

    always_comb begin
        if (w_y_wide > $signed((C_ACC_W-C_FRAC_W)'(C_RPM_MAX))) begin
            w_y_sat = C_RPM_MAX;
        end else if (w_y_wide < (C_ACC_W-C_FRAC_W)'(C_RPM_MIN)) begin
            w_y_sat = C_RPM_MIN;
        end else begin
            w_y_sat = w_y_wide[C_RPM_W-1:0];
        end
    end

    // Sequencer. Each multiplying state drives the shared multiplier with the
    // operands of one product; the product is ready in the following state.
    always_comb begin
        n_state       = r_state;
        w_mul_req.a   = '0;
        w_mul_req.b   = '0;
        w_div_req.start = 1'b0;
        w_div_req.num = r_num;
        w_div_req.den = w_prod[C_DEN_W-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc && (i_action == C_ACT_SAMPLE)) begin
                    n_state = (i_elapsed_ms == '0) ? S_OUT : S_MUL_NUM;
                end
            end
            S_MUL_NUM: begin
                // Dividend: magnitude times 60000 * 256.
                w_mul_req.a = {1'b0, r_mag};
                w_mul_req.b = {1'b0, C_RPM_SCALE};
                n_state     = S_MUL_DEN;
            end
            S_MUL_DEN: begin
                // Divisor: elapsed milliseconds times ticks per revolution.
                w_mul_req.a = {{(C_MA_W - C_MS_W){1'b0}}, r_elapsed};
                w_mul_req.b = {{(C_MB_W - C_TPR_W){1'b0}}, w_tpr};
                n_state     = S_DIV_START;
            end
            S_DIV_START: begin
                w_div_req.start = 1'b1;
                n_state         = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (w_div_rsp.done) begin
                    n_state = S_F_A;
                end
            end
            S_F_A: begin
                w_mul_req.a = {{(C_MA_W - C_RPM_W){r_y[C_RPM_W-1]}}, r_y};
                w_mul_req.b = {{(C_MB_W - C_TPR_W){1'b0}}, C_COEF_A};
                n_state     = S_F_B1;
            end
            S_F_B1: begin
                w_mul_req.a = {{(C_MA_W - C_RPM_W){r_x[C_RPM_W-1]}}, r_x};
                w_mul_req.b = {{(C_MB_W - C_TPR_W){1'b0}}, C_COEF_B};
                n_state     = S_F_B2;
            end
            S_F_B2: begin
                w_mul_req.a = {{(C_MA_W - C_RPM_W){r_xp[C_RPM_W-1]}}, r_xp};
                w_mul_req.b = {{(C_MB_W - C_TPR_W){1'b0}}, C_COEF_B};
                n_state     = S_F_SUM;
            end
            S_F_SUM: begin
                n_state = S_F_OUT;
            end
            S_F_OUT: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control and architectural state, cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_last      <= '0;
            r_y         <= '0;
            r_xp        <= '0;
            r_tpr       <= C_TPR_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (w_cfg_wr && (paddr[C_PADDR_W-1] == C_REG_TPR)) begin
                r_tpr <= pwdata[C_TPR_W-1:0];
            end

            if (w_in_acc && (i_action == C_ACT_EDGE)) begin
                if (i_other_phase == C_PHASE_UP) begin
                    r_pos <= r_pos + 1'b1;
                end else begin
                    r_pos <= r_pos - 1'b1;
                end
            end

            // Commit the filter step; a zero-time sample never reaches here.
            if (r_state == S_F_OUT) begin
                r_y    <= w_y_sat;
                r_xp   <= r_x;
                r_last <= r_pos;
            end

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers and output payload, no reset needed.
    always_ff @(posedge i_clk) begin
        if (w_in_acc && (i_action == C_ACT_SAMPLE)) begin
            r_elapsed <= i_elapsed_ms;
            r_terr    <= (i_elapsed_ms == '0);
            r_neg     <= w_delta[C_POS_W-1];
            r_mag     <= w_delta[C_POS_W-1] ? (C_POS_W'(0) - w_delta) : w_delta;
        end
        if (r_state == S_MUL_DEN) begin
            r_num <= w_prod[C_NUM_W-1:0];
        end
        if ((r_state == S_DIV_WAIT) && w_div_rsp.done) begin
            r_x <= w_x;
        end
        if (r_state == S_F_B1) begin
            r_acc <= w_prod[C_ACC_W-1:0] + C_ROUND;
        end else if ((r_state == S_F_B2) || (r_state == S_F_SUM)) begin
            r_acc <= r_acc + w_prod[C_ACC_W-1:0];
        end
        if (w_out_load) begin
            r_out_rpm  <= r_y;
            r_out_pos  <= r_pos;
            r_out_terr <= r_terr;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_filtered_rpm   = r_out_rpm;
    assign o_position_count = r_out_pos;
    assign o_time_error     = r_out_terr;

endmodule

`default_nettype wire

// ----- rtl/ewse_checker.sv -----
// Port-level checker for the wheel speed estimator, bound to the top level.
// Depends on ewse_pkg and the assertion macro header.
`default_nettype none

`include "encoder_wheel_speed_estimator_core_assert.svh"

module ewse_checker (
    input wire                                  i_clk,
    input wire                                  i_rst_n,
    input wire                                  i_in_valid,
    input wire                                  o_in_ready,
    input wire                                  i_action,
    input wire                                  o_out_valid,
    input wire                                  i_out_ready,
    input wire [ewse_pkg::C_RPM_W-1:0]          o_filtered_rpm,
    input wire [ewse_pkg::C_POS_W-1:0]          o_position_count,
    input wire                                  o_time_error
);
    import ewse_pkg::*;

    logic                       w_in_sample;
    logic                       w_in_edge;
    logic                       w_stall;
    logic [C_RPM_W+C_POS_W:0]   w_payload;

    assign w_in_sample = i_in_valid && o_in_ready && (i_action == C_ACT_SAMPLE);
    assign w_in_edge   = i_in_valid && o_in_ready && (i_action == C_ACT_EDGE);
    assign w_stall     = o_out_valid && !i_out_ready;
    assign w_payload   = {o_filtered_rpm, o_position_count, o_time_error};

    // A pending result holds until taken.
    `EWSE_ASSERT(a_out_hold, w_stall |=> o_out_valid && $stable(w_payload), "result changed")

    // Reset leaves the block idle with no result pending.
    `EWSE_ASSERT_RST(a_reset_idle, !i_rst_n |=> (!o_out_valid && o_in_ready), "not idle after reset")

    // A sample request keeps the block busy in the following cycle.
    `EWSE_ASSERT(a_sample_busy, w_in_sample |=> !o_in_ready, "ready after a sample request")

    // An edge request never creates a result.
    `EWSE_ASSERT(a_edge_silent, w_in_edge && !o_out_valid |=> !o_out_valid, "result after an edge")

endmodule

bind encoder_wheel_speed_estimator_core ewse_checker u_ewse_checker (.*);

`default_nettype wire

// ----- dv/tb_encoder_wheel_speed_estimator_core.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for encoder_wheel_speed_estimator_core: random and directed
// edge and sample requests are checked against an in-bench speed predictor.
// Depends on ewse_pkg and the RTL of the block; it reads no files.

module tb_encoder_wheel_speed_estimator_core;

    import ewse_pkg::*;

    // Filter and scaling constants of the speed estimate, kept separately from the RTL.
    localparam longint FILT_A      = 55968;      // 0.854 in Q0.16
    localparam longint FILT_B      = 4771;       // 0.0728 in Q0.16
    localparam longint FILT_ROUND  = 32768;
    localparam longint RPM_SCALE   = 15360000;   // 60000 rpm-ms in Q16.8
    localparam longint RPM_TOP     = 8388607;
    localparam longint RPM_BOTTOM  = -8388608;
    localparam int     WATCHDOG_LIMIT = 2000;
    localparam int     SETTLE_CYCLES  = 48;

    // Register addresses: the speed scale register, and index 1, which does not exist.
    localparam logic [C_PADDR_W-1:0] TPR_ADDR   = {C_REG_TPR, 2'b00};
    localparam logic [C_PADDR_W-1:0] SPARE_ADDR = 3'b100;
    localparam logic PHASE_DOWN = ~C_PHASE_UP;

    typedef struct {
        logic        action;
        logic        phase;
        logic [15:0] ms;
    } wheel_req_t;

    typedef struct {
        logic signed [C_RPM_W-1:0] rpm;
        logic [C_POS_W-1:0]        pos;
        logic                      terr;
    } speed_result_t;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_ready;
    logic                       i_action = 1'b0;
    logic                       i_other_phase = 1'b0;
    logic [C_MS_W-1:0]          i_elapsed_ms = '0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    logic signed [C_RPM_W-1:0]  o_filtered_rpm;
    logic signed [C_POS_W-1:0]  o_position_count;
    logic                       o_time_error;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [C_PADDR_W-1:0]       paddr = '0;
    logic [C_PDATA_W-1:0]       pwdata = '0;
    logic [C_PDATA_W-1:0]       prdata;
    logic                       pready;

    // Predictor state: the wheel as the block should see it.
    logic [C_POS_W-1:0]         wheel_pos = '0;
    logic [C_POS_W-1:0]         pos_at_sample = '0;
    logic signed [C_RPM_W-1:0]  filtered_speed = '0;
    logic signed [C_RPM_W-1:0]  prev_raw_speed = '0;
    logic [C_TPR_W-1:0]         ticks_setting = 16'd1050;

    wheel_req_t     pending_reqs[$];
    speed_result_t  expected_speeds[$];
    wheel_req_t     held_req;

    // Percentage chance of starting an idle burst after each request sent, or on each cycle the receiver is ready.
    int idle_pct = 0;
    int send_gap = 0;
    int stall_left = 0;
    int quiet_cycles = 0;
    int error_count = 0;
    int n_requests = 0;
    int n_samples = 0;
    int n_zero_elapsed = 0;
    int n_results = 0;
    int n_settings = 1;

    encoder_wheel_speed_estimator_core DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_action         (i_action),
        .i_other_phase    (i_other_phase),
        .i_elapsed_ms     (i_elapsed_ms),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_filtered_rpm   (o_filtered_rpm),
        .o_position_count (o_position_count),
        .o_time_error     (o_time_error),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic signed [C_RPM_W-1:0] clamp_rpm(longint v);
        if (v > RPM_TOP) return RPM_TOP[C_RPM_W-1:0];
        if (v < RPM_BOTTOM) return RPM_BOTTOM[C_RPM_W-1:0];
        return v[C_RPM_W-1:0];
    endfunction

    // Advances the wheel model by one accepted request. A sample request with
    // a non-zero elapsed time forms the raw speed from the position change,
    // runs the filter and queues the expected result; a zero elapsed time only
    // flags the error and reports the held filter output.
    function automatic void advance_wheel_model(wheel_req_t r);
        speed_result_t exp_res;
        logic [C_POS_W-1:0] moved;
        logic [C_POS_W-1:0] mag;
        longint unsigned    den;
        longint unsigned    quot;
        longint             acc;
        logic signed [C_RPM_W-1:0] raw;
        if (r.action == C_ACT_EDGE) begin
            if (r.phase == C_PHASE_UP) begin
                wheel_pos = wheel_pos + 1'b1;
            end else begin
                wheel_pos = wheel_pos - 1'b1;
            end
            return;
        end
        exp_res.terr = (r.ms == 16'd0);
        if (!exp_res.terr) begin
            moved = wheel_pos - pos_at_sample;
            mag = moved[C_POS_W-1] ? -moved : moved;
            den = 64'(r.ms) * 64'((ticks_setting == 16'd0) ? 16'd1 : ticks_setting);
            quot = (64'(mag) * 64'(RPM_SCALE)) / den;
            raw = clamp_rpm(moved[C_POS_W-1] ? -longint'(quot) : longint'(quot));
            acc = FILT_A * longint'(filtered_speed) + FILT_B * longint'(raw)
                + FILT_B * longint'(prev_raw_speed) + FILT_ROUND;
            filtered_speed = clamp_rpm(acc >>> 16);
            prev_raw_speed = raw;
            pos_at_sample = wheel_pos;
        end
        exp_res.rpm = filtered_speed;
        exp_res.pos = wheel_pos;
        expected_speeds.push_back(exp_res);
    endfunction

    // Request driver. A new request is presented only once the previous one
    // has been taken, so valid and payload hold steady while the block is busy.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            advance_wheel_model(held_req);
            n_requests++;
        end
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (send_gap > 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                held_req = pending_reqs.pop_front();
                i_in_valid <= 1'b1;
                i_action <= held_req.action;
                i_other_phase <= held_req.phase;
                i_elapsed_ms <= held_req.ms;
                if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
                    send_gap = $urandom_range(1, 4);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result monitor and receiver. Each accepted result is compared with the
    // oldest expectation; ready drops in short random bursts.
    always @(posedge i_clk) begin
        speed_result_t exp_res;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_results++;
            if (expected_speeds.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result, expected none, actual rpm %0d pos %0d err %0b",
                         $time, o_filtered_rpm, o_position_count, o_time_error);
            end else begin
                exp_res = expected_speeds.pop_front();
                if (o_filtered_rpm !== exp_res.rpm) begin
                    error_count++;
                    $display("%0t: filtered_rpm expected %0d actual %0d",
                             $time, exp_res.rpm, o_filtered_rpm);
                end
                if (o_position_count !== exp_res.pos) begin
                    error_count++;
                    $display("%0t: position_count expected %0d actual %0d",
                             $time, $signed(exp_res.pos), o_position_count);
                end
                if (o_time_error !== exp_res.terr) begin
                    error_count++;
                    $display("%0t: time_error expected %0b actual %0b",
                             $time, exp_res.terr, o_time_error);
                end
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
                stall_left = $urandom_range(1, 4);
            end
        end
    end

    // Watchdog: any handshake on either channel or the register port counts as progress.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic void push_edge(logic phase);
        wheel_req_t r;
        r.action = C_ACT_EDGE;
        r.phase = phase;
        r.ms = 16'($urandom);
        pending_reqs.push_back(r);
    endfunction

    function automatic void push_sample(logic [15:0] ms);
        wheel_req_t r;
        r.action = C_ACT_SAMPLE;
        r.phase = 1'($urandom);
        r.ms = ms;
        pending_reqs.push_back(r);
        n_samples++;
        if (ms == 16'd0) n_zero_elapsed++;
    endfunction

    // Mostly realistic sample periods, with the odd zero and full-range value.
    function automatic logic [15:0] pick_elapsed();
        int roll;
        roll = $urandom_range(0, 11);
        if (roll == 0) return 16'd0;
        if (roll < 3) return 16'($urandom_range(1, 65535));
        return 16'($urandom_range(1, 100));
    endfunction

    // Random traffic. Most of it is a steady run of edges in one direction
    // followed by a sample, as a turning wheel would give; the rest is jitter
    // with random phase, and back-to-back samples with a zero elapsed time.
    task automatic add_random_requests(int target);
        int added;
        int run_len;
        int shape;
        logic heading;
        added = 0;
        while (added < target) begin
            shape = $urandom_range(0, 9);
            if (shape < 7) begin
                run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 90)
                                                      : $urandom_range(0, 12);
                heading = 1'($urandom_range(0, 1));
                repeat (run_len) push_edge(($urandom_range(0, 15) == 0) ? ~heading : heading);
                push_sample(pick_elapsed());
                added += run_len + 1;
            end else if (shape < 9) begin
                run_len = $urandom_range(1, 6);
                repeat (run_len) push_edge(1'($urandom_range(0, 1)));
                added += run_len;
            end else begin
                push_sample(16'd0);
                push_sample(pick_elapsed());
                added += 2;
            end
        end
    endtask

    // Holds off until every queued request has gone in and every result has
    // come back, then leaves room for an edge still being counted.
    task automatic settle();
        do @(posedge i_clk);
        while (pending_reqs.size() != 0 || i_in_valid || expected_speeds.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic reg_write(logic [C_PADDR_W-1:0] addr, logic [C_PDATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk);
        while (!pready);
        if (addr == TPR_ADDR) begin
            ticks_setting = data[C_TPR_W-1:0];
            n_settings++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic reg_read_check(logic [C_PADDR_W-1:0] addr);
        logic [C_PDATA_W-1:0] want;
        want = {{(C_PDATA_W - C_TPR_W){1'b0}}, ticks_setting};
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk);
        while (!pready);
        if (prdata !== want) begin
            error_count++;
            $display("%0t: ticks_per_rev read expected %0d actual %0d", $time, want, prdata);
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        logic [C_TPR_W-1:0] mid_ticks;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at the reset scale of 1050 ticks per revolution: a
        // zero elapsed time before any movement, a few ticks up then down,
        // a held filter after movement, and sample periods at both extremes
        // and with alternating bit patterns so every bit of the field toggles.
        reg_read_check(TPR_ADDR);
        idle_pct = 25;
        push_sample(16'd0);
        repeat (3) push_edge(C_PHASE_UP);
        push_sample(16'd1);
        repeat (5) push_edge(PHASE_DOWN);
        push_sample(16'hFFFF);
        push_edge(PHASE_DOWN);
        push_sample(16'd0);
        repeat (4) push_edge(C_PHASE_UP);
        push_sample(16'h5555);
        push_sample(16'hAAAA);
        repeat (2) push_edge(PHASE_DOWN);
        push_sample(16'h8000);
        push_sample(16'h7FFF);
        push_sample(16'd10);
        settle();

        // One tick per revolution: a single tick per millisecond already
        // saturates the raw speed, in both directions.
        reg_write(TPR_ADDR, 32'd1);
        reg_read_check(TPR_ADDR);
        add_random_requests(350);
        settle();

        // Zero ticks per revolution must behave as one.
        reg_write(TPR_ADDR, 32'd0);
        reg_read_check(TPR_ADDR);
        idle_pct = 40;
        add_random_requests(250);
        settle();

        // A write to the unused register index must leave the scale alone.
        reg_write(SPARE_ADDR, 32'hFFFF_FFFF);
        reg_read_check(TPR_ADDR);
        reg_write(TPR_ADDR, {16'hFFFF, 16'hFFFF});
        reg_read_check(TPR_ADDR);
        idle_pct = 0;
        add_random_requests(300);
        settle();

        mid_ticks = 16'($urandom_range(2, 4000));
        reg_write(TPR_ADDR, {16'($urandom), mid_ticks});
        reg_read_check(TPR_ADDR);
        idle_pct = 30;
        add_random_requests(400);
        settle();

        // Final stretch at a typical scale with both sides running flat out.
        reg_write(TPR_ADDR, 32'd360);
        reg_read_check(TPR_ADDR);
        idle_pct = 0;
        add_random_requests(380);
        settle();

        if (expected_speeds.size() != 0) begin
            error_count++;
            $display("%0t: %0d expected results never arrived", $time, expected_speeds.size());
        end
        $display("Run covered %0d requests, %0d of them samples (%0d with zero elapsed time),",
                 n_requests, n_samples, n_zero_elapsed);
        $display("with %0d results checked over %0d ticks-per-revolution settings.",
                 n_results, n_settings);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
